// ===== hw/rtl/ldfs_pkg.sv =====
`timescale 1ns / 1ps

package ldfs_pkg;

  // Channel storage depth
  localparam int MAX_CHANNELS = 12;

  // Index into the level store
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Frame slot counter: command, channel slots, latch marker
  localparam int SLOT_RAW_W = $clog2(MAX_CHANNELS + 2);
  localparam int SLOT_W = (SLOT_RAW_W > 4) ? SLOT_RAW_W : 4;

  localparam int WORD_W = 16;
  localparam int LVL_W = 8;
  localparam int BITCNT_W = $clog2(WORD_W);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_VALUE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_PULSES = 3'd5;

  // Operation codes
  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_TOGGLE = 2'd1;
  localparam logic [1:0] FUNC_RAW = 2'd2;
  localparam logic [1:0] FUNC_SEND = 2'd3;

  // Request from the frame sequencer to the serializer
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] word;
    logic              latch;
    logic              fin;
  } ser_req_t;

  // Status from the serializer back to the sequencer
  typedef struct packed {
    logic done;
    logic active;
  } ser_sts_t;

endpackage

// ===== hw/rtl/ldfs_ser.sv =====
`timescale 1ns / 1ps

module ldfs_ser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ldfs_pkg::ser_req_t           req,
  output ldfs_pkg::ser_sts_t           sts,
  output logic                         out_valid,
  output logic [ldfs_pkg::WORD_W-1:0]  out_frame_word,
  output logic                         out_is_latch,
  output logic                         out_last
);
  import ldfs_pkg::*;

  logic [WORD_W-1:0]   sh_r, sh_nxt;
  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic                active_r, active_nxt;
  logic                latch_r, latch_nxt;
  logic                fin_r, fin_nxt;
  logic                valid_r, valid_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic                olatch_r, olatch_nxt;
  logic                olast_r, olast_nxt;

  // Shift one bit per cycle, MSB first, and collect it on the receive side
  always_comb begin
    sh_nxt = sh_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    active_nxt = active_r;
    latch_nxt = latch_r;
    fin_nxt = fin_r;
    valid_nxt = 1'b0;
    word_nxt = word_r;
    olatch_nxt = olatch_r;
    olast_nxt = olast_r;
    if (req.load) begin
      sh_nxt = req.word;
      cnt_nxt = '0;
      active_nxt = 1'b1;
      latch_nxt = req.latch;
      fin_nxt = req.fin;
    end else if (active_r) begin
      sh_nxt = {sh_r[WORD_W-2:0], 1'b0};
      acc_nxt = {acc_r[WORD_W-2:0], sh_r[WORD_W-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BITCNT_W'(WORD_W - 1)) begin
        active_nxt = 1'b0;
        valid_nxt = 1'b1;
        word_nxt = {acc_r[WORD_W-2:0], sh_r[WORD_W-1]};
        olatch_nxt = latch_r;
        olast_nxt = fin_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      active_r <= active_nxt;
      valid_r <= valid_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
    acc_r <= acc_nxt;
    latch_r <= latch_nxt;
    fin_r <= fin_nxt;
    word_r <= word_nxt;
    olatch_r <= olatch_nxt;
    olast_r <= olast_nxt;
  end

  assign sts.done = valid_r;
  assign sts.active = active_r;
  assign out_valid = valid_r;
  assign out_frame_word = word_r;
  assign out_is_latch = olatch_r;
  assign out_last = olast_r;

endmodule

// ===== hw/rtl/led_driver_frame_sender.sv =====
`timescale 1ns / 1ps

// LED driver frame sender. A request (start while busy is low) updates one
// channel level, except a send or a channel not below the used count. A raw
// request ends there; any other sends a frame: the command word, the used
// channel levels, off_value for unused slots and a latch marker (14 items at
// twelve channels). Every word passes through a 16-bit shift register one
// bit per cycle. Results appear for one cycle on out_valid and cannot be
// held off; a frame keeps busy high until its latch marker has been shown.
module led_driver_frame_sender (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_func,
  input  logic [3:0]                       in_channel,
  input  logic [7:0]                       in_brightness,
  input  logic [7:0]                       in_raw_level,
  output logic                             out_valid,
  output logic [15:0]                      out_frame_word,
  output logic                             out_is_latch,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [ldfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ldfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ldfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_WORD = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_CHANNELS);
  localparam logic [SLOT_W-1:0] SLOT_LATCH = SLOT_W'(MAX_CHANNELS + 1);

  // Configuration registers
  logic [3:0]        led_count_r;
  logic              reverse_r;
  logic [WORD_W-1:0] command_r;
  logic [LVL_W-1:0]  on_r;
  logic [LVL_W-1:0]  off_r;
  logic [4:0]        latch_pulses_r;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        func_r;
  logic [3:0]        chan_r;
  logic [7:0]        bright_r;
  logic [7:0]        raw_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LVL_W-1:0]  lvl_r [MAX_CHANNELS];

  logic [SLOT_W-1:0] led_ext;
  logic [SLOT_W-1:0] used;
  logic [SLOT_W-1:0] chan_ext;
  logic              chan_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic [SLOT_W-1:0] rd_sel;
  logic [CH_W-1:0]   rd_idx;
  logic [LVL_W-1:0]  rd_lvl;
  logic              lvl_we;
  logic [LVL_W-1:0]  lvl_wdata;
  logic [LVL_W-1:0]  on_shift;
  logic              accept;
  ser_req_t          ser_req;
  ser_sts_t          ser_sts;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= 4'd12;
      reverse_r <= 1'b0;
      command_r <= '0;
      on_r <= 8'hFF;
      off_r <= '0;
      latch_pulses_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LED_COUNT:    led_count_r <= cfg_data[3:0];
        REG_REVERSE:      reverse_r <= cfg_data[0];
        REG_COMMAND:      command_r <= cfg_data[WORD_W-1:0];
        REG_ON_VALUE:     on_r <= cfg_data[LVL_W-1:0];
        REG_OFF_VALUE:    off_r <= cfg_data[LVL_W-1:0];
        REG_LATCH_PULSES: latch_pulses_r <= cfg_data[4:0];
        default:          ;
      endcase
    end
  end

  // Cap the used count at the storage depth
  assign led_ext = SLOT_W'(led_count_r);
  assign used = (led_ext > SLOT_MAX) ? SLOT_MAX : led_ext;
  assign chan_ext = SLOT_W'(chan_r);
  assign chan_ok = (chan_ext < used);

  // Level slot for the current frame position, forward or reversed
  assign slot_idx = reverse_r ? (used - slot_r) : (slot_r - 1'b1);
  assign rd_sel = (state_r == ST_APPLY) ? chan_ext : slot_idx;
  assign rd_idx = rd_sel[CH_W-1:0];
  assign rd_lvl = lvl_r[rd_idx];

  // Compute the new channel level
  assign on_shift = on_r << bright_r[7:5];
  always_comb begin
    lvl_we = (state_r == ST_APPLY) && chan_ok && (func_r != FUNC_SEND);
    case (func_r)
      FUNC_SET:    lvl_wdata = ~on_shift;
      FUNC_TOGGLE: lvl_wdata = (rd_lvl != '0) ? off_r : on_r;
      FUNC_RAW:    lvl_wdata = raw_r;
      default:     lvl_wdata = rd_lvl;
    endcase
  end

  // Hold channel levels, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (lvl_we) begin
      lvl_r[rd_idx] <= lvl_wdata;
    end
  end

  // Pick the word for the current slot and hand it to the serializer
  always_comb begin
    ser_req.load = (state_r == ST_WORD);
    ser_req.latch = 1'b0;
    ser_req.fin = 1'b0;
    if (slot_r == '0) begin
      ser_req.word = command_r;
    end else if (slot_r <= used) begin
      ser_req.word = WORD_W'(rd_lvl);
    end else if (slot_r <= SLOT_MAX) begin
      ser_req.word = WORD_W'(off_r);
    end else begin
      ser_req.word = '0;
      ser_req.latch = 1'b1;
      ser_req.fin = 1'b1;
    end
  end

  // Sequence one request through its frame
  always_comb begin
    state_nxt = state_r;
    slot_nxt = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        slot_nxt = '0;
        state_nxt = (func_r == FUNC_RAW) ? ST_IDLE : ST_WORD;
      end
      ST_WORD: begin
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (ser_sts.done) begin
          if (slot_r == SLOT_LATCH) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
            state_nxt = ST_WORD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
    end
    if (accept) begin
      func_r <= in_func;
      chan_r <= in_channel;
      bright_r <= in_brightness;
      raw_r <= in_raw_level;
    end
  end

  ldfs_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (ser_req),
    .sts            (ser_sts),
    .out_valid      (out_valid),
    .out_frame_word (out_frame_word),
    .out_is_latch   (out_is_latch),
    .out_last       (out_last)
  );

  // Results only appear while a request is in flight
  a_out_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_SHIFT))
    else $error("result strobe outside a frame");

  // The latch marker ends the request
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy)
    else $error("busy after final item");

  // Serializer is never reloaded while shifting
  a_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
    ser_sts.active |-> !ser_req.load)
    else $error("serializer reloaded mid-word");

  // The user must hold the latch pulse count while busy; the block does not enforce it
  a_latch_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(latch_pulses_r))
    else $error("latch pulse count changed during a frame");

endmodule
